// ===== src/jdsa_pkg.sv =====
// shared types, codes and bit-serial helpers for the joystick setpoint adjuster
package jdsa_pkg;

  localparam int unsigned SETPOINT_W = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 8;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CLAMP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_CLAMP   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MIN = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX = CFG_IDX_W'(5);

  // display modes
  localparam logic [MODE_W-1:0] MODE_AUTO = 3'd0;
  localparam logic [MODE_W-1:0] MODE_JOY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CD3  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CD2  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CD1  = 3'd4;

  localparam logic [STEP_W-1:0] STEP_CAP = 3'd5;

  // reset values
  localparam logic [11:0]           DEAD_LOW_RST     = 12'd2700;
  localparam logic [11:0]           DEAD_HIGH_RST    = 12'd3300;
  localparam logic [11:0]           LOW_CLAMP_RST    = 12'd100;
  localparam logic [11:0]           HIGH_CLAMP_RST   = 12'd4000;
  localparam logic [SETPOINT_W-1:0] SETPOINT_MIN_RST = 8'd1;
  localparam logic [SETPOINT_W-1:0] SETPOINT_MAX_RST = 8'd20;
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST     = 8'd5;

  // one serial divide-by-span lane: compares 4*d against 1s, 2s, 3s and 4s
  typedef struct packed {
    logic d1;  // d delayed one bit
    logic d2;  // d delayed two bits, the 4*d stream
    logic s1;  // s delayed one bit, the 2*s stream
    logic s2;  // s delayed two bits, the 4*s stream
    logic c3;  // carry of the 3*s adder
    logic b1;
    logic b2;
    logic b3;
    logic b4;
  } lane_t;

  function automatic logic sub_bo(logic x, logic y, logic bi);
    return (~x & (y | bi)) | (y & bi);
  endfunction

  function automatic logic add_co(logic a, logic b, logic ci);
    return (a & b) | (a & ci) | (b & ci);
  endfunction

  function automatic lane_t lane_step(lane_t l, logic d, logic s);
    lane_t n;
    logic  s3;
    s3   = s ^ l.s1 ^ l.c3;
    n.c3 = add_co(s, l.s1, l.c3);
    n.b1 = sub_bo(l.d2, s, l.b1);
    n.b2 = sub_bo(l.d2, l.s1, l.b2);
    n.b3 = sub_bo(l.d2, s3, l.b3);
    n.b4 = sub_bo(l.d2, l.s2, l.b4);
    n.d2 = l.d1;
    n.d1 = d;
    n.s2 = l.s1;
    n.s1 = s;
    return n;
  endfunction

  // quotient floor(4d/s), capped at 4: how many of s, 2s, 3s and 4s fit under 4d
  function automatic logic [STEP_W-1:0] lane_quot(lane_t l);
    return STEP_W'(!l.b1) + STEP_W'(!l.b2) + STEP_W'(!l.b3) + STEP_W'(!l.b4);
  endfunction

endpackage

// ===== src/jdsa_if.sv =====
// valid/ready channel interfaces: sample in, result out, config write
interface jdsa_sample_if #(
  parameter int unsigned SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic                   sample_present;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, sample_present, adc_sample, input ready);
  modport sink   (input valid, sample_present, adc_sample, output ready);
endinterface

interface jdsa_result_if import jdsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SETPOINT_W-1:0] setpoint;
  logic [MODE_W-1:0]     display_mode;
  logic                  stick_active;

  modport source (output valid, setpoint, display_mode, stick_active, input ready);
  modport sink   (input valid, setpoint, display_mode, stick_active, output ready);
endinterface

interface jdsa_cfg_if import jdsa_pkg::*; #(
  parameter int unsigned DATA_W = 12
) ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/joystick_deadzone_setpoint_adjust.sv =====
// joystick dead-zone setpoint adjuster, bit-serial compare and step divider
//
//   channel   dir  transfer when        payload
//   sample_i  in   valid & ready        sample_present, adc_sample
//   result_o  out  valid & ready        setpoint, display_mode, stick_active
//   cfg_i     in   valid & ready        index (register number), data
//
// each item goes through the states idle, run and fin: idle takes the sample,
// run does the lsb-first pass that runs all bound compares, the deflection and
// span subtracts and the 4*d/span divide, and fin commits setpoint and mode
// into the result register.
// the commit waits while the result register still holds an untaken result;
// a new sample is taken as soon as the commit is done.
// reset loads the register defaults, setpoint 5 and mode auto; config is always ready.
module joystick_deadzone_setpoint_adjust import jdsa_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  jdsa_sample_if.sink    sample_i,
  jdsa_result_if.source  result_o,
  jdsa_cfg_if.sink       cfg_i
);

  localparam int unsigned        RUN_CYCLES = SAMPLE_BITS + 3;
  localparam int unsigned        CNT_W      = $clog2(RUN_CYCLES);
  localparam logic [CNT_W-1:0]   LAST_CNT   = CNT_W'(RUN_CYCLES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  // config registers
  smp_t                  dead_low_q, dead_high_q, low_clamp_q, high_clamp_q;
  logic [SETPOINT_W-1:0] sp_min_q, sp_max_q;

  // block state
  logic [SETPOINT_W-1:0] sp_q, sp_d;
  logic [MODE_W-1:0]     mode_q, mode_d;

  // sequencer
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q;

  // serial operand shift registers, lsb leaves first
  smp_t adc_sr_q, dl_sr_q, dh_sr_q, lc_sr_q, hc_sr_q;
  logic present_q;

  // borrows of the serial subtracts and compares
  logic b_dlo_q, b_slo_q, b_dhi_q, b_shi_q;   // dl-adc, dl-lc, adc-dh, hc-dh
  logic b_adc_dl_q, b_lc_dl_q, b_adc_lc_q;    // adc<dl, lc<dl, adc<lc
  logic b_dh_adc_q, b_dh_hc_q, b_hc_adc_q;    // adc>dh, hc>dh, adc>hc
  lane_t lane_lo_q, lane_hi_q;

  // result register
  logic                  res_valid_q;
  logic [SETPOINT_W-1:0] res_sp_q;
  logic [MODE_W-1:0]     res_mode_q;
  logic                  res_act_q;

  logic in_xfer, out_xfer, out_free, commit;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_xfer        = sample_i.valid && sample_i.ready;
  assign out_xfer       = res_valid_q && result_o.ready;
  assign out_free       = !res_valid_q || result_o.ready;
  assign commit         = (state_q == ST_FIN) && out_free;

  assign cfg_i.ready = 1'b1;

  assign result_o.valid        = res_valid_q;
  assign result_o.setpoint     = res_sp_q;
  assign result_o.display_mode = res_mode_q;
  assign result_o.stick_active = res_act_q;

  // ---------------------------------------------------------------------------
  // config writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_low_q   <= SAMPLE_BITS'(DEAD_LOW_RST);
      dead_high_q  <= SAMPLE_BITS'(DEAD_HIGH_RST);
      low_clamp_q  <= SAMPLE_BITS'(LOW_CLAMP_RST);
      high_clamp_q <= SAMPLE_BITS'(HIGH_CLAMP_RST);
      sp_min_q     <= SETPOINT_MIN_RST;
      sp_max_q     <= SETPOINT_MAX_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_DEAD_LOW:     dead_low_q   <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_DEAD_HIGH:    dead_high_q  <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_LOW_CLAMP:    low_clamp_q  <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_HIGH_CLAMP:   high_clamp_q <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_SETPOINT_MIN: sp_min_q     <= cfg_i.data[SETPOINT_W-1:0];
        REG_SETPOINT_MAX: sp_max_q     <= cfg_i.data[SETPOINT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // serial pass: one bit of every operand per cycle
  // ---------------------------------------------------------------------------
  logic a_b, dl_b, dh_b, lc_b, hc_b;
  logic dlo_b, slo_b, dhi_b, shi_b;

  assign a_b  = adc_sr_q[0];
  assign dl_b = dl_sr_q[0];
  assign dh_b = dh_sr_q[0];
  assign lc_b = lc_sr_q[0];
  assign hc_b = hc_sr_q[0];

  // deflection and span bits, each side
  assign dlo_b = dl_b ^ a_b  ^ b_dlo_q;
  assign slo_b = dl_b ^ lc_b ^ b_slo_q;
  assign dhi_b = a_b  ^ dh_b ^ b_dhi_q;
  assign shi_b = hc_b ^ dh_b ^ b_shi_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      adc_sr_q   <= sample_i.adc_sample;
      dl_sr_q    <= dead_low_q;
      dh_sr_q    <= dead_high_q;
      lc_sr_q    <= low_clamp_q;
      hc_sr_q    <= high_clamp_q;
      present_q  <= sample_i.sample_present;
      b_dlo_q    <= 1'b0;
      b_slo_q    <= 1'b0;
      b_dhi_q    <= 1'b0;
      b_shi_q    <= 1'b0;
      b_adc_dl_q <= 1'b0;
      b_lc_dl_q  <= 1'b0;
      b_adc_lc_q <= 1'b0;
      b_dh_adc_q <= 1'b0;
      b_dh_hc_q  <= 1'b0;
      b_hc_adc_q <= 1'b0;
      lane_lo_q  <= '0;
      lane_hi_q  <= '0;
    end else if (state_q == ST_RUN) begin
      // zeros shift in above the msb so the pass can run past the sample width
      adc_sr_q   <= adc_sr_q >> 1;
      dl_sr_q    <= dl_sr_q >> 1;
      dh_sr_q    <= dh_sr_q >> 1;
      lc_sr_q    <= lc_sr_q >> 1;
      hc_sr_q    <= hc_sr_q >> 1;
      b_dlo_q    <= sub_bo(dl_b, a_b, b_dlo_q);
      b_slo_q    <= sub_bo(dl_b, lc_b, b_slo_q);
      b_dhi_q    <= sub_bo(a_b, dh_b, b_dhi_q);
      b_shi_q    <= sub_bo(hc_b, dh_b, b_shi_q);
      b_adc_dl_q <= sub_bo(a_b, dl_b, b_adc_dl_q);
      b_lc_dl_q  <= sub_bo(lc_b, dl_b, b_lc_dl_q);
      b_adc_lc_q <= sub_bo(a_b, lc_b, b_adc_lc_q);
      b_dh_adc_q <= sub_bo(dh_b, a_b, b_dh_adc_q);
      b_dh_hc_q  <= sub_bo(dh_b, hc_b, b_dh_hc_q);
      b_hc_adc_q <= sub_bo(hc_b, a_b, b_hc_adc_q);
      lane_lo_q  <= lane_step(lane_lo_q, dlo_b, slo_b);
      lane_hi_q  <= lane_step(lane_hi_q, dhi_b, shi_b);
    end
  end

  // ---------------------------------------------------------------------------
  // commit: pick the side, form the step, saturate, advance the mode
  // ---------------------------------------------------------------------------
  logic              low_hit, high_hit, active;
  logic [STEP_W-1:0] step_lo, step_hi;
  logic [SETPOINT_W:0] inc_sum, dec_floor;

  assign low_hit  = present_q && b_adc_dl_q;
  assign high_hit = present_q && !b_adc_dl_q && b_dh_adc_q;
  assign active   = low_hit || high_hit;

  // span zero or negative, or sample beyond the clamp: full step
  assign step_lo = (!b_lc_dl_q || b_adc_lc_q) ? STEP_CAP
                                              : STEP_W'(1) + lane_quot(lane_lo_q);
  assign step_hi = (!b_dh_hc_q || b_hc_adc_q) ? STEP_CAP
                                              : STEP_W'(1) + lane_quot(lane_hi_q);

  assign inc_sum   = {1'b0, sp_q} + (SETPOINT_W + 1)'(step_lo);
  assign dec_floor = {1'b0, sp_min_q} + (SETPOINT_W + 1)'(step_hi);

  always_comb begin
    sp_d = sp_q;
    if (low_hit) begin
      sp_d = (inc_sum <= {1'b0, sp_max_q}) ? inc_sum[SETPOINT_W-1:0] : sp_max_q;
    end else if (high_hit) begin
      sp_d = ({1'b0, sp_q} > dec_floor) ? (sp_q - SETPOINT_W'(step_hi)) : sp_min_q;
    end

    if (active) begin
      mode_d = MODE_JOY;
    end else begin
      case (mode_q)
        MODE_AUTO: mode_d = MODE_AUTO;
        MODE_JOY:  mode_d = MODE_CD3;
        MODE_CD3:  mode_d = MODE_CD2;
        MODE_CD2:  mode_d = MODE_CD1;
        default:   mode_d = MODE_AUTO;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_RUN;
      ST_RUN:  if (cnt_q == LAST_CNT) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RUN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= SETPOINT_RST;
      mode_q      <= MODE_AUTO;
      res_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        sp_q        <= sp_d;
        mode_q      <= mode_d;
        res_valid_q <= 1'b1;
      end else if (out_xfer) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_sp_q   <= sp_d;
      res_mode_q <= mode_d;
      res_act_q  <= active;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result appeared without a commit");

  a_take_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("sample transfer did not start the serial pass");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= LAST_CNT))
    else $error("pass counter overran");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_mode_q <= MODE_CD1))
    else $error("result mode outside the defined codes");

  a_active_joy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_act_q) |-> (res_mode_q == MODE_JOY))
    else $error("stick active without joy mode");

endmodule

// ===== tb/joystick_deadzone_setpoint_adjust_test.sv =====
// self-checking testbench for the joystick dead-zone setpoint adjuster
module joystick_deadzone_setpoint_adjust_test import jdsa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS = 12;
  // one item's time through the block, used to size the closing wait
  localparam int unsigned ITEM_CYCLES = SAMPLE_BITS + 5;
  localparam int unsigned SEG_ITEMS   = 38;

  // one tick's outcome as seen on the result channel
  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint;
    logic [MODE_W-1:0]     display_mode;
    logic                  stick_active;
  } tick_outcome_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  jdsa_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
  jdsa_result_if                              result_bus ();
  jdsa_cfg_if    #(.DATA_W(12))               cfg_bus ();

  joystick_deadzone_setpoint_adjust #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  always #4 clk = ~clk;

  // predictor copy of the thresholds, limits and state
  logic [11:0]           dead_low_m;
  logic [11:0]           dead_high_m;
  logic [11:0]           low_clamp_m;
  logic [11:0]           high_clamp_m;
  logic [SETPOINT_W-1:0] sp_min_m;
  logic [SETPOINT_W-1:0] sp_max_m;
  logic [SETPOINT_W-1:0] setpoint_m;
  logic [MODE_W-1:0]     mode_m;

  tick_outcome_t outcomes_due[$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // step grows with deflection: 1 + 4*defl/span, capped; zero span gives the cap
  function automatic logic [STEP_W-1:0] step_for(logic [11:0] defl, logic [11:0] span);
    logic [13:0] quot;
    if (span == '0) return STEP_CAP;
    quot = {defl, 2'b00} / {2'b00, span};
    if (quot >= 14'd4) return STEP_CAP;
    return STEP_W'(quot) + STEP_W'(1);
  endfunction

  // advance the predicted state by one tick and return what the block must show
  function automatic tick_outcome_t advance_adjuster(logic present, logic [11:0] adc);
    logic [11:0]       lvl;
    logic [STEP_W-1:0] step;
    logic [8:0]        sum;
    logic              active;
    tick_outcome_t     o;
    lvl    = adc;
    active = 1'b0;
    if (present) begin
      // low side is tested first, so it wins when the bounds overlap
      if (lvl < dead_low_m) begin
        if (low_clamp_m >= dead_low_m) begin
          step = STEP_CAP;
        end else begin
          if (lvl < low_clamp_m) lvl = low_clamp_m;
          step = step_for(dead_low_m - lvl, dead_low_m - low_clamp_m);
        end
        // no wrap: a setpoint above the maximum falls to it
        sum        = {1'b0, setpoint_m} + 9'(step);
        setpoint_m = (sum <= {1'b0, sp_max_m}) ? sum[7:0] : sp_max_m;
        active     = 1'b1;
      end else if (lvl > dead_high_m) begin
        if (high_clamp_m <= dead_high_m) begin
          step = STEP_CAP;
        end else begin
          if (lvl > high_clamp_m) lvl = high_clamp_m;
          step = step_for(lvl - dead_high_m, high_clamp_m - dead_high_m);
        end
        sum        = {1'b0, sp_min_m} + 9'(step);
        setpoint_m = ({1'b0, setpoint_m} > sum) ? setpoint_m - SETPOINT_W'(step) : sp_min_m;
        active     = 1'b1;
      end
    end
    if (active) begin
      mode_m = MODE_JOY;
    end else begin
      case (mode_m)
        MODE_AUTO: mode_m = MODE_AUTO;
        MODE_JOY:  mode_m = MODE_CD3;
        MODE_CD3:  mode_m = MODE_CD2;
        MODE_CD2:  mode_m = MODE_CD1;
        default:   mode_m = MODE_AUTO;
      endcase
    end
    o.setpoint     = setpoint_m;
    o.display_mode = mode_m;
    o.stick_active = active;
    return o;
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] data);
    case (idx)
      REG_DEAD_LOW:     dead_low_m   = data;
      REG_DEAD_HIGH:    dead_high_m  = data;
      REG_LOW_CLAMP:    low_clamp_m  = data;
      REG_HIGH_CLAMP:   high_clamp_m = data;
      REG_SETPOINT_MIN: sp_min_m     = data[7:0];
      REG_SETPOINT_MAX: sp_max_m     = data[7:0];
      default:          ;
    endcase
  endfunction

  // one sample transfer; called and returns at a falling edge, valid left high
  task automatic send_tick(logic present, logic [11:0] adc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid          <= 1'b1;
    sample_bus.sample_present <= present;
    sample_bus.adc_sample     <= adc;
    do @(posedge clk); while (!sample_bus.ready);
    outcomes_due.push_back(advance_adjuster(present, adc));
    @(negedge clk);
  endtask

  // stop sending and hold off until every predicted outcome has been seen
  task automatic wait_for_outcomes();
    sample_bus.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    store_reg(idx, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // registers are only written with the block idle
  task automatic apply_config(logic [11:0] dl, logic [11:0] dh, logic [11:0] lc,
                              logic [11:0] hc, logic [7:0] mn, logic [7:0] mx);
    wait_for_outcomes();
    write_reg(REG_DEAD_LOW, dl);
    write_reg(REG_DEAD_HIGH, dh);
    write_reg(REG_LOW_CLAMP, lc);
    write_reg(REG_HIGH_CLAMP, hc);
    // upper data bits are don't-care for the 8-bit limits
    write_reg(REG_SETPOINT_MIN, {4'($urandom), mn});
    write_reg(REG_SETPOINT_MAX, {4'($urandom), mx});
  endtask

  // reset settings: extremes of the sample and both dead-zone edges
  task automatic test_basic();
    send_tick(1'b0, 12'd3000);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'hFFF);
    send_tick(1'b1, 12'd2699);
    send_tick(1'b1, 12'd3301);
    send_tick(1'b1, 12'd2700);
    send_tick(1'b1, 12'd3300);
  endtask

  // joy, then count 3, 2, 1 back to auto; a missing sample counts as idle
  task automatic test_countdown();
    send_tick(1'b1, 12'd0);
    send_tick(1'b0, 12'hFFF);
    send_tick(1'b1, 12'd2700);
    send_tick(1'b0, 12'd0);
    send_tick(1'b1, 12'd3000);
    send_tick(1'b0, 12'hA5A);
  endtask

  // clamp past the bound on the low side, clamp on the bound on the high side
  task automatic test_zero_span();
    apply_config(12'd2000, 12'd2500, 12'd2100, 12'd2500, 8'd1, 8'd20);
    send_tick(1'b1, 12'd1999);
    send_tick(1'b1, 12'd2501);
  endtask

  // dead_low above dead_high: a sample under both rules takes the low side
  task automatic test_overlap();
    apply_config(12'd3000, 12'd1000, 12'd100, 12'd4000, 8'd1, 8'd20);
    send_tick(1'b1, 12'd2000);
    send_tick(1'b1, 12'd3500);
  endtask

  // widest bounds and full setpoint range, then a setpoint outside min..max
  task automatic test_limits();
    apply_config(12'd4095, 12'd0, 12'd0, 12'd4095, 8'd0, 8'd255);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'hFFF);
    apply_config(DEAD_LOW_RST, DEAD_HIGH_RST, LOW_CLAMP_RST, HIGH_CLAMP_RST, 8'd250, 8'd3);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'hFFF);
    send_tick(1'b1, 12'd0);
  endtask

  task automatic random_setting(int kind);
    int dl, dh, lc, hc, mn, mx;
    case (kind)
      0: begin
        // well-ordered bounds with a narrow setpoint window
        dl = $urandom_range(200, 2500);
        dh = $urandom_range(dl, 3800);
        lc = $urandom_range(0, dl - 1);
        hc = $urandom_range(dh + 1, 4095);
        mn = $urandom_range(0, 40);
        mx = $urandom_range(mn, mn + 60);
      end
      1: begin
        // each register at or next to one end of its range
        dl = $urandom_range(0, 1) ? 4095 : 1;
        dh = $urandom_range(0, 1) ? 4094 : 0;
        lc = $urandom_range(0, 1) ? 4094 : 0;
        hc = $urandom_range(0, 1) ? 4095 : 1;
        mn = $urandom_range(0, 1) ? 255 : 0;
        mx = $urandom_range(0, 1) ? 255 : 0;
      end
      2: begin
        dl = $urandom_range(1, 4095);
        dh = $urandom_range(0, 4094);
        lc = $urandom_range(0, 4094);
        hc = $urandom_range(1, 4095);
        mn = $urandom_range(0, 255);
        mx = $urandom_range(0, 255);
      end
      default: begin
        dl = DEAD_LOW_RST;
        dh = DEAD_HIGH_RST;
        lc = LOW_CLAMP_RST;
        hc = HIGH_CLAMP_RST;
        mn = SETPOINT_MIN_RST;
        mx = SETPOINT_MAX_RST;
      end
    endcase
    apply_config(12'(dl), 12'(dh), 12'(lc), 12'(hc), 8'(mn), 8'(mx));
  endtask

  // a stroke: a burst of deflected samples on one side, then idle ticks;
  // a share of strokes are single random items as noise
  task automatic random_stroke(output int sent);
    int   n_defl, n_idle;
    logic low_side;
    sent = 0;
    if ($urandom_range(0, 99) < 15) begin
      send_tick(1'($urandom), 12'($urandom));
      sent = 1;
      return;
    end
    low_side = 1'($urandom);
    n_defl   = $urandom_range(1, 6);
    n_idle   = $urandom_range(0, 6);
    repeat (n_defl) begin
      if (low_side)
        send_tick(1'b1, 12'($urandom_range(0, int'(dead_low_m) - 1)));
      else
        send_tick(1'b1, 12'($urandom_range(int'(dead_high_m) + 1, 4095)));
    end
    repeat (n_idle) begin
      if ($urandom_range(0, 1) && dead_low_m <= dead_high_m)
        send_tick(1'b1, 12'($urandom_range(dead_low_m, dead_high_m)));
      else
        send_tick(1'b0, 12'($urandom));
    end
    sent = n_defl + n_idle;
  endtask

  // three idling phases, each walking through the four kinds of setting
  task automatic test_random();
    int sent, n;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 8;  recv_idle_pct = 63; end
        1:       begin send_idle_pct = 63; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        random_setting(seg);
        sent = 0;
        while (sent < SEG_ITEMS) begin
          random_stroke(n);
          sent += n;
          // now and then let the pipeline run dry mid-stream
          if ($urandom_range(0, 99) < 4) wait_for_outcomes();
        end
      end
    end
  endtask

  // receiver stalls at random; ready changes on the falling edge only
  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    tick_outcome_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result sp=%0d mode=%0d act=%0b",
                                  result_bus.setpoint, result_bus.display_mode,
                                  result_bus.stick_active));
      end else begin
        want = outcomes_due.pop_front();
        if (result_bus.setpoint !== want.setpoint ||
            result_bus.display_mode !== want.display_mode ||
            result_bus.stick_active !== want.stick_active) begin
          report_mismatch($sformatf("got sp=%0d mode=%0d act=%0b, want sp=%0d mode=%0d act=%0b",
                                    result_bus.setpoint, result_bus.display_mode,
                                    result_bus.stick_active, want.setpoint,
                                    want.display_mode, want.stick_active));
        end
      end
    end
  end

  initial begin
    sample_bus.valid          = 1'b0;
    sample_bus.sample_present = 1'b0;
    sample_bus.adc_sample     = '0;
    result_bus.ready          = 1'b0;
    cfg_bus.valid             = 1'b0;
    cfg_bus.index             = '0;
    cfg_bus.data              = '0;
    dead_low_m   = DEAD_LOW_RST;
    dead_high_m  = DEAD_HIGH_RST;
    low_clamp_m  = LOW_CLAMP_RST;
    high_clamp_m = HIGH_CLAMP_RST;
    sp_min_m     = SETPOINT_MIN_RST;
    sp_max_m     = SETPOINT_MAX_RST;
    setpoint_m   = SETPOINT_RST;
    mode_m       = MODE_AUTO;
    send_idle_pct = 8;
    recv_idle_pct = 63;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic();
    test_countdown();
    test_zero_span();
    test_overlap();
    test_limits();
    test_random();

    wait_for_outcomes();
    repeat (2 * ITEM_CYCLES) @(negedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
    if (mismatches == 0) begin
      $display("joystick_deadzone_setpoint_adjust test passed");
    end else begin
      $display("joystick_deadzone_setpoint_adjust test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("joystick_deadzone_setpoint_adjust test failed");
    $finish;
  end

endmodule
